/* design/trc_pkg.sv */
package trc_pkg;

  localparam int WHEELS     = 3;
  localparam int WHEEL_SIZE = 26;

  localparam logic [1:0] ACT_LOAD     = 2'd0;
  localparam logic [1:0] ACT_TURN     = 2'd1;
  localparam logic [1:0] ACT_ENCIPHER = 2'd2;
  localparam logic [1:0] ACT_DECIPHER = 2'd3;

  localparam logic [7:0] LOWER_FIRST = 8'd97;
  localparam logic [7:0] LOWER_LAST  = 8'd122;
  localparam logic [7:0] LOWER_BASE  = 8'd96;
  localparam logic [7:0] UPPER_FIRST = 8'd65;
  localparam logic [7:0] UPPER_LAST  = 8'd90;
  localparam logic [7:0] UPPER_BASE  = 8'd64;

  localparam logic [4:0] SIZE_5 = 5'd26;
  localparam logic [4:0] LAST_5 = 5'd25;
  localparam logic [5:0] SIZE_6 = 6'd26;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] wheel;
    logic [4:0] position;
    logic [4:0] wiring_value;
    logic [4:0] turns;
    logic [7:0] letter_code;
  } trc_in_t;

  typedef struct packed {
    logic [6:0] letter_out;
    logic       invalid_input;
    logic       no_match;
  } trc_out_t;

  // Command broadcast from the sequencer to one rotor cell
  typedef struct packed {
    logic       load;
    logic       turn;
    logic [4:0] pos;
    logic [4:0] val;
    logic [4:0] turns;
  } cell_cmd_t;

  // Letter to 1..26, zero for anything that is not a letter
  function automatic logic [4:0] letter_code_of(input logic [7:0] ch);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (ch >= LOWER_FIRST && ch <= LOWER_LAST) begin
        d = ch - LOWER_BASE;
      end else if (ch >= UPPER_FIRST && ch <= UPPER_LAST) begin
        d = ch - UPPER_BASE;
      end
      return d[4:0];
    end
  endfunction

  // (v + 25) mod 26 for any 5-bit wiring value
  function automatic logic [4:0] wrap_index(input logic [4:0] v);
    logic [4:0] r;
    begin
      if (v == 5'd0) begin
        r = LAST_5;
      end else if (v > SIZE_5) begin
        r = v - 5'd27;
      end else begin
        r = v - 5'd1;
      end
      return r;
    end
  endfunction

endpackage

/* design/trc_rotor_cell.sv */
module trc_rotor_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  trc_pkg::cell_cmd_t  cmd,
  input  logic                step_in,
  output logic                carry_out,
  input  logic [4:0]          rd_pos,
  output logic [4:0]          rd_val
);

  logic [4:0] wiring_r [trc_pkg::WHEEL_SIZE];
  logic [4:0] offset_r, offset_nxt;
  logic [4:0] count_r, count_nxt;
  logic [4:0] turn_red;
  logic [5:0] turn_sum;
  logic [5:0] src_raw;
  logic [4:0] src_idx;

  assign turn_red = (cmd.turns >= trc_pkg::SIZE_5) ? cmd.turns - trc_pkg::SIZE_5 : cmd.turns;
  assign turn_sum = {1'b0, offset_r} + {1'b0, turn_red};

  assign carry_out = step_in && (count_r == trc_pkg::LAST_5);

  always_comb begin
    offset_nxt = offset_r;
    count_nxt  = count_r;
    if (cmd.turn) begin
      offset_nxt = (turn_sum >= trc_pkg::SIZE_6) ? 5'(turn_sum - trc_pkg::SIZE_6)
                                                 : turn_sum[4:0];
    end else if (step_in) begin
      offset_nxt = (offset_r == trc_pkg::LAST_5) ? 5'd0 : offset_r + 5'd1;
      count_nxt  = (count_r == trc_pkg::LAST_5) ? 5'd0 : count_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= 5'd0;
      count_r  <= 5'd0;
    end else begin
      offset_r <= offset_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wiring_r[cmd.pos] <= cmd.val;
    end
  end

  // Undo the right rotation: source entry is (pos - offset) mod 26
  assign src_raw = {1'b0, rd_pos} + trc_pkg::SIZE_6 - {1'b0, offset_r};
  assign src_idx = (src_raw >= trc_pkg::SIZE_6) ? 5'(src_raw - trc_pkg::SIZE_6)
                                                : src_raw[4:0];
  assign rd_val  = wiring_r[src_idx];

endmodule

/* design/three_wheel_rotor_cipher_top.sv */
// Encipher: one lookup per rotor cell in ST_FWD, first wheel to last, then ST_DONE.
// Decipher: a search from the last wheel back to the first, one wiring entry per cycle,
// ending early with no_match; a non-letter goes straight to ST_DONE with invalid_input.
// Load and turn words are taken in ST_IDLE and produce no result. A new word is taken
// only in ST_IDLE, once the last result has left ST_DONE, which a stalled output delays.
// Synchronous active-low reset clears offsets, step counts and control; wiring is not cleared.
module three_wheel_rotor_cipher_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  trc_pkg::trc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output trc_pkg::trc_out_t out_data
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_FWD    = 4'b0010,
    ST_SEARCH = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [1:0]         widx_r, widx_nxt;
  logic [4:0]         pos_r, pos_nxt;
  logic [4:0]         val_r, val_nxt;
  logic [4:0]         hit_r, hit_nxt;
  trc_pkg::trc_out_t  res_r, res_nxt;
  trc_pkg::trc_out_t  out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               accept;
  logic               cipher_acc;
  logic [4:0]         code;
  logic [4:0]         rd_pos;
  logic [4:0]         entry;
  logic [4:0]         final_hit;
  logic [4:0]         cell_val [trc_pkg::WHEELS];
  logic [trc_pkg::WHEELS:0] carry;
  trc_pkg::cell_cmd_t cmd [trc_pkg::WHEELS];

  assign in_stall   = (state_r != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign cipher_acc = accept && (in_data.action == trc_pkg::ACT_ENCIPHER ||
                                 in_data.action == trc_pkg::ACT_DECIPHER);
  assign code       = trc_pkg::letter_code_of(in_data.letter_code);

  assign carry[0] = cipher_acc;

  for (genvar i = 0; i < trc_pkg::WHEELS; i++) begin : g_cell
    always_comb begin
      cmd[i].load  = accept && (in_data.action == trc_pkg::ACT_LOAD) &&
                     (in_data.wheel == 2'(i)) && (in_data.position < trc_pkg::SIZE_5);
      cmd[i].turn  = accept && (in_data.action == trc_pkg::ACT_TURN) &&
                     (in_data.wheel == 2'(i));
      cmd[i].pos   = in_data.position;
      cmd[i].val   = in_data.wiring_value;
      cmd[i].turns = in_data.turns;
    end

    trc_rotor_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd[i]),
      .step_in   (carry[i]),
      .carry_out (carry[i+1]),
      .rd_pos    (rd_pos),
      .rd_val    (cell_val[i])
    );
  end

  // Forward lookups index by the previous value, the search by the scan position
  assign rd_pos    = (state_r == ST_SEARCH) ? pos_r : trc_pkg::wrap_index(val_r);
  assign entry     = cell_val[widx_r];
  assign final_hit = (entry == val_r) ? trc_pkg::SIZE_5 : hit_r;

  always_comb begin
    state_nxt     = state_r;
    widx_nxt      = widx_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    hit_nxt       = hit_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      ST_IDLE: begin
        if (cipher_acc) begin
          val_nxt = code;
          pos_nxt = 5'd0;
          hit_nxt = 5'd0;
          res_nxt = '0;
          if (code == 5'd0) begin
            res_nxt.invalid_input = 1'b1;
            state_nxt = ST_DONE;
          end else if (in_data.action == trc_pkg::ACT_ENCIPHER) begin
            widx_nxt  = 2'd0;
            state_nxt = ST_FWD;
          end else begin
            widx_nxt  = 2'(trc_pkg::WHEELS - 1);
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_FWD: begin
        val_nxt = entry;
        if (widx_r == 2'(trc_pkg::WHEELS - 1)) begin
          res_nxt.letter_out = trc_pkg::UPPER_FIRST[6:0] +
                               {2'b00, trc_pkg::wrap_index(entry)};
          state_nxt = ST_DONE;
        end else begin
          widx_nxt = widx_r + 2'd1;
        end
      end
      ST_SEARCH: begin
        // keep the last matching position, 1-based
        if (entry == val_r) begin
          hit_nxt = pos_r + 5'd1;
        end
        if (pos_r == trc_pkg::LAST_5) begin
          pos_nxt = 5'd0;
          hit_nxt = 5'd0;
          if (final_hit == 5'd0) begin
            res_nxt.no_match = 1'b1;
            state_nxt = ST_DONE;
          end else if (widx_r == 2'd0) begin
            res_nxt.letter_out = trc_pkg::UPPER_BASE[6:0] + {2'b00, final_hit};
            state_nxt = ST_DONE;
          end else begin
            val_nxt  = final_hit;
            widx_nxt = widx_r - 2'd1;
          end
        end else begin
          pos_nxt = pos_r + 5'd1;
        end
      end
      ST_DONE: begin
        // hand over once the output register is free or being drained
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    widx_r <= widx_nxt;
    pos_r  <= pos_nxt;
    val_r  <= val_nxt;
    hit_r  <= hit_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
